FILE: design/u8d_pkg.sv
package u8d_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int CP_W             = 21;
  localparam int ST_W             = 3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_LEAD = 3'd1;
  localparam logic [ST_W-1:0] ST_MISSING  = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERLONG = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;
  localparam logic [ST_W-1:0] ST_TRUNC    = 3'd5;

  // results produced by one byte, at most two
  typedef struct packed {
    logic [1:0] count;
  } step_ctl_t;

endpackage

FILE: design/u8d_decode.sv
module u8d_decode #(
  parameter int OFFSET_WIDTH = u8d_pkg::OFFSET_WIDTH_DEF,
  localparam int RES_W = u8d_pkg::CP_W + u8d_pkg::ST_W + OFFSET_WIDTH + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                end_of_text,
  output u8d_pkg::step_ctl_t  ctl,
  output logic [RES_W-1:0]    res0,
  output logic [RES_W-1:0]    res1
);

  localparam int PAY_W = RES_W - 1;

  // sequence state
  logic [20:0]             code_accumulator, code_accumulator_next;
  logic [1:0]              trails_remaining, trails_remaining_next;
  logic [2:0]              sequence_length, sequence_length_next;
  logic [OFFSET_WIDTH-1:0] byte_position, byte_position_next;
  logic [OFFSET_WIDTH-1:0] sequence_start, sequence_start_next;

  logic [PAY_W-1:0] slot [2];
  logic [1:0]       cnt;
  logic [20:0]      acc_sh;
  logic [20:0]      floor_cp;
  logic             is_trail;
  logic             do_lead;
  logic             bad_range;

  function automatic logic [PAY_W-1:0] pack(input logic [20:0] cp,
                                            input logic [2:0] st,
                                            input logic [OFFSET_WIDTH-1:0] start);
    pack = {start, st, cp};
  endfunction

  always_comb begin
    code_accumulator_next = code_accumulator;
    trails_remaining_next = trails_remaining;
    sequence_length_next  = sequence_length;
    sequence_start_next   = sequence_start;
    slot[0]               = '0;
    slot[1]               = '0;
    cnt                   = 2'd0;
    is_trail              = (data_byte[7:6] == 2'b10);
    acc_sh                = {code_accumulator[14:0], data_byte[5:0]};
    bad_range             = (acc_sh > 21'h10FFFF) ||
                            ((acc_sh >= 21'h00D800) && (acc_sh <= 21'h00DFFF));
    floor_cp              = (sequence_length == 3'd2) ? 21'h000080 :
                            (sequence_length == 3'd3) ? 21'h000800 : 21'h010000;
    do_lead               = 1'b1;

    if (trails_remaining != 2'd0) begin
      if (is_trail) begin
        do_lead               = 1'b0;
        code_accumulator_next = acc_sh;
        trails_remaining_next = trails_remaining - 2'd1;
        if (trails_remaining == 2'd1) begin
          if (bad_range) begin
            slot[cnt[0]] = pack('0, u8d_pkg::ST_RANGE, sequence_start);
          end else if (acc_sh < floor_cp) begin
            slot[cnt[0]] = pack('0, u8d_pkg::ST_OVERLONG, sequence_start);
          end else begin
            slot[cnt[0]] = pack(acc_sh, u8d_pkg::ST_OK, sequence_start);
          end
          cnt                   = cnt + 2'd1;
          code_accumulator_next = '0;
          sequence_length_next  = '0;
        end
      end else begin
        // sequence broken: report it, then treat this byte as a lead
        slot[cnt[0]]          = pack('0, u8d_pkg::ST_MISSING, sequence_start);
        cnt                   = cnt + 2'd1;
        code_accumulator_next = '0;
        trails_remaining_next = '0;
        sequence_length_next  = '0;
      end
    end

    if (do_lead) begin
      if (data_byte[7] == 1'b0) begin
        slot[cnt[0]] = pack({13'd0, data_byte}, u8d_pkg::ST_OK, byte_position);
        cnt          = cnt + 2'd1;
      end else if (data_byte[7:5] == 3'b110) begin
        sequence_length_next  = 3'd2;
        trails_remaining_next = 2'd1;
        code_accumulator_next = {16'd0, data_byte[4:0]};
        sequence_start_next   = byte_position;
      end else if (data_byte[7:4] == 4'hE) begin
        sequence_length_next  = 3'd3;
        trails_remaining_next = 2'd2;
        code_accumulator_next = {17'd0, data_byte[3:0]};
        sequence_start_next   = byte_position;
      end else if (data_byte[7:3] == 5'b11110) begin
        sequence_length_next  = 3'd4;
        trails_remaining_next = 2'd3;
        code_accumulator_next = {18'd0, data_byte[2:0]};
        sequence_start_next   = byte_position;
      end else begin
        slot[cnt[0]] = pack('0, u8d_pkg::ST_BAD_LEAD, byte_position);
        cnt          = cnt + 2'd1;
      end
    end

    if (end_of_text) begin
      if (trails_remaining_next != 2'd0) begin
        slot[cnt[0]]          = pack('0, u8d_pkg::ST_TRUNC, sequence_start_next);
        cnt                   = cnt + 2'd1;
        code_accumulator_next = '0;
        trails_remaining_next = '0;
        sequence_length_next  = '0;
      end
      byte_position_next = '0;
    end else begin
      byte_position_next = byte_position + OFFSET_WIDTH'(1);
    end
  end

  assign ctl.count = cnt;
  assign res0      = {(cnt == 2'd1), slot[0]};
  assign res1      = {1'b1, slot[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accumulator <= '0;
      trails_remaining <= '0;
      sequence_length  <= '0;
      byte_position    <= '0;
      sequence_start   <= '0;
    end else if (take) begin
      code_accumulator <= code_accumulator_next;
      trails_remaining <= trails_remaining_next;
      sequence_length  <= sequence_length_next;
      byte_position    <= byte_position_next;
      sequence_start   <= sequence_start_next;
    end
  end

endmodule

FILE: design/utf8_decoder_validator.sv
// A result is offered on m_tvalid at the earliest in the cycle after the byte is taken.
// Throughput: one byte per cycle while s_tready is high; a byte that yields two results
// (broken sequence plus the retried lead's result or its cut-short report) takes two slots.
// The 4-entry result queue sets the rate: a byte is taken when two slots are free.
// Reset (rst, synchronous, active high) clears the decoder state, the offset
// and the queue; nothing is pending afterwards.
module utf8_decoder_validator #(
  parameter int OFFSET_WIDTH = u8d_pkg::OFFSET_WIDTH_DEF,
  localparam int FIELD_W = u8d_pkg::CP_W + u8d_pkg::ST_W + OFFSET_WIDTH,
  localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  // byte stream in
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic               s_tlast,   // end_of_text
  // decoded results out
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // code_point[20:0], status, start_offset
  output logic               m_tlast    // last_result
);

  localparam int RES_W = FIELD_W + 1;
  localparam int DEPTH = 4;

  logic               in_take;
  logic               out_take;
  u8d_pkg::step_ctl_t ctl;
  logic [RES_W-1:0]   res0, res1;

  // result queue: entries laid out {last, offset, status, code_point}
  logic [RES_W-1:0] queue [DEPTH];
  logic [1:0]       wr_ptr, rd_ptr;
  logic [2:0]       count, count_next;
  logic [RES_W-1:0] head;

  u8d_decode #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .take        (in_take),
    .data_byte   (s_tdata),
    .end_of_text (s_tlast),
    .ctl         (ctl),
    .res0        (res0),
    .res1        (res1)
  );

  // room for the worst case of two results per byte
  assign s_tready = (count <= 3'(DEPTH - 2));
  assign in_take  = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  assign head     = queue[rd_ptr];
  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = TDATA_W'(head[FIELD_W-1:0]);
  assign m_tlast  = head[RES_W-1];

  always_comb begin
    count_next = count;
    if (in_take) begin
      count_next = count_next + {1'b0, ctl.count};
    end
    if (out_take) begin
      count_next = count_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (out_take) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (in_take) begin
        wr_ptr <= wr_ptr + ctl.count;
      end
    end
  end

  // payload writes, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (ctl.count != 2'd0) begin
        queue[wr_ptr] <= res0;
      end
      if (ctl.count == 2'd2) begin
        queue[wr_ptr + 2'd1] <= res1;
      end
    end
  end

`ifndef ASSERT_OFF
  // queue never overflows
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH))
    else $error("result queue overflow");

  // a byte that yields results makes output valid next cycle
  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    (in_take && (ctl.count != 2'd0)) |=> m_tvalid)
    else $error("result missing after request");

  // errors carry a zero code point
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[23:21] != u8d_pkg::ST_OK)) |-> (m_tdata[20:0] == 21'd0))
    else $error("error result with nonzero code point");

  // status stays within the defined codes
  a_status_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:21] <= u8d_pkg::ST_TRUNC))
    else $error("undefined status code");
`endif

endmodule

FILE: verif/testbench.sv
module testbench;
  import u8d_pkg::*;

  localparam int OFF_W = 32;
  localparam int TD_W  = ((CP_W + ST_W + OFF_W + 7) / 8) * 8;

  // one decoded result as it should leave the block
  typedef struct {
    logic [CP_W-1:0]  cp;
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] offset;
    logic             last;
  } decoded_t;

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [7:0]      s_tdata;   // [7:0] data_byte
  logic            s_tlast;   // end_of_text
  logic            m_tvalid;
  logic            m_tready;
  logic [TD_W-1:0] m_tdata;   // code_point, status, start_offset (low to high)
  logic            m_tlast;   // last_result

  utf8_decoder_validator #(
    .OFFSET_WIDTH(OFF_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // expected decoder results, oldest first
  decoded_t decoded_q[$];
  // results caused by the byte being predicted
  decoded_t step_results[$];

  // decoder state mirrored on the testbench side
  logic [CP_W-1:0]  acc_bits   = '0;
  logic [1:0]       trails_left = '0;
  logic [2:0]       open_len   = '0;
  logic [OFF_W-1:0] byte_pos   = '0;
  logic [OFF_W-1:0] open_start = '0;

  int mismatches      = 0;
  int send_idle_pct   = 0;   // chance that the sender skips a cycle
  int recv_stall_pct  = 0;   // chance that the receiver drops tready
  int hold_off_cycles = 0;   // long receiver hold-off, counted down below

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the handshakes hang
  initial begin
    #1600000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void note_result(input logic [CP_W-1:0] cp,
                                      input logic [ST_W-1:0] status,
                                      input logic [OFF_W-1:0] offset);
    decoded_t r;
    r.cp     = cp;
    r.status = status;
    r.offset = offset;
    r.last   = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void drop_open_seq();
    acc_bits    = '0;
    trails_left = '0;
    open_len    = '0;
  endfunction

  // byte seen with no sequence open: ASCII, a lead, or a stray byte
  function automatic void decode_lead(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      note_result({13'd0, b}, ST_OK, byte_pos);
    end else if (b[7:5] == 3'b110) begin
      open_len = 3'd2; trails_left = 2'd1;
      acc_bits = {16'd0, b[4:0]}; open_start = byte_pos;
    end else if (b[7:4] == 4'b1110) begin
      open_len = 3'd3; trails_left = 2'd2;
      acc_bits = {17'd0, b[3:0]}; open_start = byte_pos;
    end else if (b[7:3] == 5'b11110) begin
      open_len = 3'd4; trails_left = 2'd3;
      acc_bits = {18'd0, b[2:0]}; open_start = byte_pos;
    end else begin
      note_result('0, ST_BAD_LEAD, byte_pos);
    end
  endfunction

  // called once per accepted request; queues up to two results
  function automatic void predict_decode(input logic [7:0] b, input logic eot);
    logic [CP_W-1:0] min_cp;
    logic [ST_W-1:0] st;
    step_results.delete();
    if (trails_left != 0) begin
      if (b[7:6] == 2'b10) begin
        acc_bits    = {acc_bits[CP_W-7:0], b[5:0]};
        trails_left = trails_left - 2'd1;
        if (trails_left == 0) begin
          min_cp = (open_len == 3'd2) ? 21'h80 : (open_len == 3'd3) ? 21'h800 : 21'h10000;
          st = ST_OK;
          // range first, so a surrogate never reads as overlong
          if (acc_bits > 21'h10FFFF || (acc_bits >= 21'hD800 && acc_bits <= 21'hDFFF)) begin
            st = ST_RANGE;
          end else if (acc_bits < min_cp) begin
            st = ST_OVERLONG;
          end
          note_result((st == ST_OK) ? acc_bits : '0, st, open_start);
          drop_open_seq();
        end
      end else begin
        // broken sequence: report it, then retry the byte as a lead
        note_result('0, ST_MISSING, open_start);
        drop_open_seq();
        decode_lead(b);
      end
    end else begin
      decode_lead(b);
    end
    if (eot) begin
      if (trails_left != 0) begin
        note_result('0, ST_TRUNC, open_start);
        drop_open_seq();
      end
      byte_pos = '0;
    end else begin
      byte_pos = byte_pos + OFF_W'(1);
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size()-1].last = 1'b1;
    end
    foreach (step_results[i]) decoded_q.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: drives at negedge, sees acceptance at posedge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eot);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);   // junk while idle, must be ignored
      s_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_decode(b, eot);
  endtask

  task automatic send_run(input logic [7:0] bytes_q[$], input logic eot_at_end);
    foreach (bytes_q[i]) send_byte(bytes_q[i], eot_at_end && (i == bytes_q.size() - 1));
  endtask

  // lower valid and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    decoded_t got;
    decoded_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.cp     = m_tdata[CP_W-1:0];
      got.status = m_tdata[CP_W +: ST_W];
      got.offset = m_tdata[CP_W+ST_W +: OFF_W];
      got.last   = m_tlast;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result cp=%h st=%0d off=%0d",
                                  got.cp, got.status, got.offset));
      end else begin
        want = decoded_q.pop_front();
        if (got.cp !== want.cp)
          report_mismatch($sformatf("code_point %h, want %h", got.cp, want.cp));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.offset !== want.offset)
          report_mismatch($sformatf("start_offset %0d, want %0d", got.offset, want.offset));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_result %0b, want %0b", got.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // ASCII extremes and stray bytes; end of text on ASCII resets the offset
  task automatic test_single_byte_leads();
    send_run('{8'h00}, 1'b0);
    send_run('{8'h7F}, 1'b1);
    send_run('{8'h80, 8'hFF, 8'hF8}, 1'b0);
    drain_results();
  endtask

  // completed sequences: good, overlong (C0 lead), surrogate, above max,
  // and the all-ones payload of a 4-byte lead
  task automatic test_sequence_checks();
    send_run('{8'hC2, 8'h80}, 1'b0);
    send_run('{8'hC0, 8'h80}, 1'b0);
    send_run('{8'hED, 8'hA0, 8'h80}, 1'b0);
    send_run('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
    send_run('{8'hF7, 8'hBF, 8'hBF, 8'hBF}, 1'b0);
    drain_results();
  endtask

  // missing trail then retried lead; missing trail plus cut short by end of
  // text in one byte; a lead alone at end of text
  task automatic test_broken_sequences();
    send_run('{8'hC3, 8'h41}, 1'b0);
    send_run('{8'hE2, 8'hC3}, 1'b1);
    send_run('{8'hE0}, 1'b1);
    drain_results();
  endtask

  // Mostly well-formed text with random scalar values; the rest is raw
  // payloads (overlong/surrogate/too large), sequences cut short, and noise.
  task automatic test_random_text(input int n_bytes, input int idle_pct, input int stall_pct);
    logic [7:0]      seq_q[$];
    logic [CP_W-1:0] cp;
    int              sent;
    int              kind;
    int              len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(99);
      len  = $urandom_range(1, 4);
      cp   = CP_W'($urandom);
      if (kind < 60) begin
        case (len)
          1: cp = CP_W'($urandom_range(21'h7F, 0));
          2: cp = CP_W'($urandom_range(21'h7FF, 21'h80));
          3: begin
            cp = CP_W'($urandom_range(21'hFFFF, 21'h800));
            while (cp >= 21'hD800 && cp <= 21'hDFFF) begin
              cp = CP_W'($urandom_range(21'hFFFF, 21'h800));
            end
          end
          default: cp = CP_W'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
      end
      seq_q.delete();
      case (len)
        1: seq_q = '{{1'b0, cp[6:0]}};
        2: seq_q = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
        3: seq_q = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
        default: seq_q = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                           {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      endcase
      if (kind >= 75 && kind < 88 && len > 1) begin
        repeat ($urandom_range(len - 1, 1)) void'(seq_q.pop_back());
      end else if (kind >= 88) begin
        seq_q = '{8'($urandom)};
      end
      foreach (seq_q[i]) begin
        send_byte(seq_q[i], $urandom_range(29) == 0);
        sent++;
      end
    end
    drain_results();
  endtask

  // receiver holds off for a long stretch while bytes keep coming, so the
  // result queue fills and the block must stop taking requests
  task automatic test_output_stall();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 150;
    for (int i = 0; i < 40; i++) begin
      // ASCII, stray bytes and lone leads at end of text: all give results
      case ($urandom_range(2))
        0: send_byte(8'($urandom_range(8'h7F, 0)), 1'b0);
        1: send_byte(8'($urandom_range(8'hBF, 8'h80)), 1'b0);
        default: send_byte({3'b110, 5'($urandom)}, 1'b1);
      endcase
    end
    drain_results();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_byte_leads();
    test_sequence_checks();
    test_broken_sequences();
    test_random_text(220, 0, 0);
    test_random_text(150, 79, 0);
    test_random_text(150, 0, 79);
    test_random_text(150, 18, 18);
    test_output_stall();
    test_random_text(60, 0, 0);

    // anything still owed after a bounded wait is a failure
    recv_stall_pct = 0;
    for (int i = 0; i < 20000 && decoded_q.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/u8d_pkg.sv
design/u8d_decode.sv
design/utf8_decoder_validator.sv
verif/testbench.sv
